// ===== rtl/awtc_pkg.sv =====
// Package for the write-through cache: item types, field widths and defaults.
`timescale 1ns / 1ps
`default_nettype none

package awtc_pkg;

   // Field widths of one item
   localparam int ADDRESS_W   = 10;
   localparam int DATA_W      = 32;
   localparam int LINE_USED_W = 3;

   // Parameter defaults
   localparam int LINES_DEFAULT     = 8;
   localparam int ADDR_BITS_DEFAULT = 10;
   localparam int AGE_BITS_DEFAULT  = 16;

   // Access codes
   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   typedef struct packed {
      logic                      action;
      logic [ADDRESS_W-1:0]      address;
      logic signed [DATA_W-1:0]  write_data;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  read_data;
      logic                      hit;
      logic [LINE_USED_W-1:0]    line_used;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/assoc_write_through_cache.sv =====
// Fully associative write-through cache with age-based victim choice, top level.
// A read hit, or a write that finds its tag or a free line, ends the scan on that line;
// otherwise the scan covers every line and then fills a victim line. One tag and age compare
// unit walks the lines one per cycle out of the line RAM, so a new item is taken only after
// the previous result. After reset the backing memory is zeroed by a clearing pass over
// every word, during which busy is high. The result strobe lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none

module assoc_write_through_cache
   import awtc_pkg::*;
#(
   parameter int LINES     = LINES_DEFAULT,
   parameter int ADDR_BITS = ADDR_BITS_DEFAULT,
   parameter int AGE_BITS  = AGE_BITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   localparam int LW = $clog2(LINES);
   localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;
   localparam logic [LW-1:0]       LAST_IDX = LW'(LINES - 1);

   typedef struct packed {
      logic [ADDR_BITS-1:0] tag;
      logic [DATA_W-1:0]    data;
      logic [AGE_BITS-1:0]  age;
   } line_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FILL
   } state_type;

   // Registers
   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [LINES-1:0]     valid_ff, valid_in;
   logic                 action_ff, action_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0]    wdata_ff, wdata_in;
   logic [LW-1:0]        cur_ff, cur_in;
   logic                 best_set_ff, best_set_in;
   logic [AGE_BITS-1:0]  best_age_ff, best_age_in;
   logic [LW-1:0]        best_idx_ff, best_idx_in;
   logic                 inv_found_ff, inv_found_in;
   logic [LW-1:0]        inv_idx_ff, inv_idx_in;
   logic [LW-1:0]        victim_ff, victim_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_item_ff, rsp_item_in;

   // Memory ports
   logic                 line_wr_en, line_rd_en;
   logic [LW-1:0]        line_wr_addr, line_rd_addr;
   line_type             line_wr_data, line_q;
   logic                 mem_wr_en, mem_rd_en;
   logic [ADDR_BITS-1:0] mem_wr_addr, mem_rd_addr;
   logic [DATA_W-1:0]    mem_wr_data, mem_q;

   // Scan datapath
   logic [ADDR_BITS+ADDRESS_W-1:0] addr_ext;
   logic [LW+LINE_USED_W-1:0]      cur_ext, victim_ext;
   logic                 accept;
   logic                 is_write;
   logic                 cur_valid;
   logic                 tag_eq;
   logic                 stop;
   logic [AGE_BITS-1:0]  age_inc;
   logic [AGE_BITS-1:0]  cand_age;
   logic                 better;

   assign accept   = start && (state_ff == ST_IDLE);
   assign addr_ext = {{ADDR_BITS{1'b0}}, req_item.address};
   assign is_write = (action_ff == ACTION_WRITE);

   // Compare the line arriving from the line RAM
   assign cur_valid = valid_ff[cur_ff];
   assign tag_eq    = (line_q.tag == addr_ff);
   assign age_inc   = (line_q.age == AGE_MAX) ? line_q.age : line_q.age + AGE_BITS'(1);
   assign cand_age  = is_write ? line_q.age : age_inc;
   assign better    = cur_valid && (!best_set_ff || (cand_age > best_age_ff));
   assign stop      = is_write ? (!cur_valid || tag_eq) : (cur_valid && tag_eq);
   assign cur_ext    = {{LINE_USED_W{1'b0}}, cur_ff};
   assign victim_ext = {{LINE_USED_W{1'b0}}, victim_ff};

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      valid_in      = valid_ff;
      action_in     = action_ff;
      addr_in       = addr_ff;
      wdata_in      = wdata_ff;
      cur_in        = cur_ff;
      best_set_in   = best_set_ff;
      best_age_in   = best_age_ff;
      best_idx_in   = best_idx_ff;
      inv_found_in  = inv_found_ff;
      inv_idx_in    = inv_idx_ff;
      victim_in     = victim_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;

      line_wr_en   = 1'b0;
      line_wr_addr = cur_ff;
      line_wr_data = '{tag: addr_ff, data: wdata_ff, age: '0};
      line_rd_en   = 1'b0;
      line_rd_addr = cur_ff + LW'(1);
      mem_wr_en    = 1'b0;
      mem_wr_addr  = addr_ff;
      mem_wr_data  = wdata_ff;
      mem_rd_en    = accept;
      mem_rd_addr  = addr_ext[ADDR_BITS-1:0];

      unique case (state_ff)
         // Zero the backing memory one word a cycle
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + ADDR_BITS'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         // Latch the item and start reading line zero
         ST_IDLE: begin
            if (accept) begin
               action_in    = req_item.action;
               addr_in      = addr_ext[ADDR_BITS-1:0];
               wdata_in     = req_item.write_data;
               cur_in       = '0;
               best_set_in  = 1'b0;
               inv_found_in = 1'b0;
               line_rd_en   = 1'b1;
               line_rd_addr = '0;
               state_in     = ST_SCAN;
            end
         end

         // Check one line a cycle
         ST_SCAN: begin
            if (stop) begin
               rsp_strobe_in        = 1'b1;
               rsp_item_in.line_used = cur_ext[LINE_USED_W-1:0];
               state_in             = ST_IDLE;
               if (is_write) begin
                  line_wr_en            = 1'b1;
                  valid_in[cur_ff]      = 1'b1;
                  mem_wr_en             = 1'b1;
                  rsp_item_in.read_data = '0;
                  rsp_item_in.hit       = cur_valid;
               end else begin
                  rsp_item_in.read_data = line_q.data;
                  rsp_item_in.hit       = 1'b1;
               end
            end else begin
               // Age the line on a read, track first invalid and oldest line
               if (!is_write && cur_valid) begin
                  line_wr_en   = 1'b1;
                  line_wr_data = '{tag: line_q.tag, data: line_q.data, age: age_inc};
               end
               if (better) begin
                  best_set_in = 1'b1;
                  best_age_in = cand_age;
                  best_idx_in = cur_ff;
               end
               if (!cur_valid && !inv_found_ff) begin
                  inv_found_in = 1'b1;
                  inv_idx_in   = cur_ff;
               end
               if (cur_ff == LAST_IDX) begin
                  priority if (inv_found_ff) begin
                     victim_in = inv_idx_ff;
                  end else if (!cur_valid || better) begin
                     victim_in = cur_ff;
                  end else begin
                     victim_in = best_idx_ff;
                  end
                  state_in = ST_FILL;
               end else begin
                  line_rd_en = 1'b1;
                  cur_in     = cur_ff + LW'(1);
               end
            end
         end

         // Fill the victim line and finish the item
         ST_FILL: begin
            line_wr_en            = 1'b1;
            line_wr_addr          = victim_ff;
            valid_in[victim_ff]   = 1'b1;
            rsp_strobe_in         = 1'b1;
            rsp_item_in.hit       = 1'b0;
            rsp_item_in.line_used = victim_ext[LINE_USED_W-1:0];
            state_in              = ST_IDLE;
            if (is_write) begin
               mem_wr_en             = 1'b1;
               rsp_item_in.read_data = '0;
            end else begin
               line_wr_data          = '{tag: addr_ff, data: mem_q, age: '0};
               rsp_item_in.read_data = mem_q;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      action_ff    <= action_in;
      addr_ff      <= addr_in;
      wdata_ff     <= wdata_in;
      cur_ff       <= cur_in;
      best_set_ff  <= best_set_in;
      best_age_ff  <= best_age_in;
      best_idx_ff  <= best_idx_in;
      inv_found_ff <= inv_found_in;
      inv_idx_ff   <= inv_idx_in;
      victim_ff    <= victim_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // Line tags, data and ages
   awtc_ram #(
      .WIDTH ($bits(line_type)),
      .DEPTH (LINES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (line_wr_addr),
      .wr_data (line_wr_data),
      .rd_en   (line_rd_en),
      .rd_addr (line_rd_addr),
      .rd_data (line_q)
   );

   // Backing word memory
   awtc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (2 ** ADDR_BITS)
   ) u_mem_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_q)
   );

endmodule

`default_nettype wire

// ===== rtl/awtc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module awtc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
